FILE: src/tsp_pkg.sv
// Shared types and constants for the transport stream packet header parser.
// No dependencies.
`default_nettype none

package tsp_pkg;

    localparam int POS_W = 8;

    localparam logic [7:0] SYNC_MARK = 8'h47;

    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_PAYLOAD  = 2'd1,
        KIND_SYNC_ERR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       record_kind;
        logic [12:0] packet_id;
        logic        transport_error;
        logic        unit_start;
        logic        priority_bit;
        logic [1:0]  scrambling;
        logic [1:0]  adaptation_control;
        logic [3:0]  continuity;
        logic [7:0]  adaptation_length;
        logic [7:0]  adaptation_flags;
        logic [7:0]  payload_length;
        logic [7:0]  payload_data;
    } t_record;

endpackage

`default_nettype wire

FILE: src/tsp_in_stage.sv
// Input register for stream words.
// Depends on nothing outside this file.
`default_nettype none

module tsp_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_take,
    output logic            o_valid,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

`default_nettype wire

FILE: src/tsp_decoder.sv
// Packet position tracking, header capture and record formation.
// Uses tsp_pkg for the record type and constants.
`default_nettype none

module tsp_decoder
    import tsp_pkg::*;
#(
    parameter int PACKET_BYTES = 188
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_only_adapt,
    output logic            o_has,
    output t_record         o_rec
);

    localparam logic [POS_W:0] PKT_LEN = (POS_W + 1)'(PACKET_BYTES);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_dropped, n_dropped;
    logic [23:0]      r_held_header, n_held_header;
    logic [7:0]       r_held_alen, n_held_alen;
    logic [POS_W-1:0] r_payload_start, n_payload_start;

    logic [23:0]      hdr_use;
    logic [1:0]       ctl;
    logic             hdr_emit;
    logic [7:0]       emit_alen;
    logic [7:0]       emit_aflags;
    logic [POS_W-1:0] emit_ps;
    logic [POS_W:0]   alen_sum;
    logic [POS_W:0]   pos_inc;
    logic [POS_W:0]   plen_diff;

    // at byte 3 the header is only complete with the incoming byte
    assign hdr_use  = (r_pos == POS_W'(3)) ? {r_held_header[15:0], i_byte} : r_held_header;
    assign ctl      = hdr_use[5:4];
    assign alen_sum = (POS_W + 1)'(i_byte) + (POS_W + 1)'(5);
    assign pos_inc  = (POS_W + 1)'(r_pos) + (POS_W + 1)'(1);
    assign plen_diff = PKT_LEN - (POS_W + 1)'(emit_ps);

    always_comb begin
        n_pos           = (pos_inc >= PKT_LEN) ? '0 : pos_inc[POS_W-1:0];
        n_dropped       = r_dropped;
        n_held_header   = r_held_header;
        n_held_alen     = r_held_alen;
        n_payload_start = r_payload_start;
        hdr_emit        = 1'b0;
        emit_alen       = 8'd0;
        emit_aflags     = 8'd0;
        emit_ps         = r_payload_start;
        o_has           = 1'b0;
        o_rec           = '0;

        if (r_pos == '0) begin
            n_dropped = (i_byte != SYNC_MARK);
            if (i_byte != SYNC_MARK) begin
                o_has             = 1'b1;
                o_rec.record_kind = KIND_SYNC_ERR;
            end
        end else if (!r_dropped) begin
            priority if (r_pos <= POS_W'(3)) begin
                n_held_header = {r_held_header[15:0], i_byte};
                if (r_pos == POS_W'(3)) begin
                    n_held_alen = 8'd0;
                    if (ctl[1]) begin
                        n_payload_start = PKT_LEN[POS_W-1:0];
                    end else begin
                        n_payload_start = POS_W'(4);
                        emit_ps         = POS_W'(4);
                        hdr_emit        = 1'b1;
                    end
                end
            end else if (ctl[1] && r_pos == POS_W'(4)) begin
                n_held_alen     = i_byte;
                n_payload_start = (alen_sum > PKT_LEN) ? PKT_LEN[POS_W-1:0]
                                                       : alen_sum[POS_W-1:0];
                if (i_byte == 8'd0) begin
                    emit_ps  = POS_W'(5);
                    hdr_emit = 1'b1;
                end
            end else if (ctl[1] && r_pos == POS_W'(5) && r_held_alen != 8'd0) begin
                emit_alen   = r_held_alen;
                emit_aflags = i_byte;
                hdr_emit    = 1'b1;
            end else if (ctl[0] && r_pos >= r_payload_start) begin
                o_has              = 1'b1;
                o_rec.record_kind  = KIND_PAYLOAD;
                o_rec.payload_data = i_byte;
            end
        end

        // filter: header only for packets with an adaptation field when asked
        if (hdr_emit && !(i_only_adapt && !ctl[1])) begin
            o_has                    = 1'b1;
            o_rec.record_kind        = KIND_HEADER;
            o_rec.packet_id          = hdr_use[20:8];
            o_rec.transport_error    = hdr_use[23];
            o_rec.unit_start         = hdr_use[22];
            o_rec.priority_bit       = hdr_use[21];
            o_rec.scrambling         = hdr_use[7:6];
            o_rec.adaptation_control = ctl;
            o_rec.continuity         = hdr_use[3:0];
            o_rec.adaptation_length  = emit_alen;
            o_rec.adaptation_flags   = emit_aflags;
            o_rec.payload_length     = (ctl[0] && (POS_W + 1)'(emit_ps) < PKT_LEN)
                                       ? plen_diff[7:0] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos           <= '0;
            r_dropped       <= 1'b0;
            r_held_header   <= '0;
            r_held_alen     <= '0;
            r_payload_start <= '0;
        end else if (i_fire) begin
            r_pos           <= n_pos;
            r_dropped       <= n_dropped;
            r_held_header   <= n_held_header;
            r_held_alen     <= n_held_alen;
            r_payload_start <= n_payload_start;
        end
    end

endmodule

`default_nettype wire

FILE: src/tsp_out_stage.sv
// Result register holding one record until the consumer takes it.
// Uses tsp_pkg for the record type.
`default_nettype none

module tsp_out_stage
    import tsp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire logic    i_has,
    input  wire t_record i_rec,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_record      o_rec
);

    logic    r_valid;
    t_record r_rec;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_has;
        end
        if (o_free && i_load && i_has) begin
            r_rec <= i_rec;
        end
    end

endmodule

`default_nettype wire

FILE: src/ts_packet_header_parser.sv
// Top level of the transport stream packet header parser.
// Uses tsp_pkg, tsp_in_stage, tsp_decoder and tsp_out_stage.
//
// Takes one stream word per cycle unless stalled and splits the stream into
// PACKET_BYTES-byte packets with a position counter. Each byte passes an input
// register, is decoded against the packet state and leaves through a result
// register: one byte per clock sustained unless the consumer stalls. Header
// bytes that complete no record produce nothing. A bad sync byte gives a
// sync-error record and mutes the rest of that packet. The config register is
// sampled when a header record is formed; write it while idle.
`default_nettype none

module ts_packet_header_parser
    import tsp_pkg::*;
#(
    parameter int PACKET_BYTES = 188
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_stream_valid,
    output logic             o_stream_ready,
    input  wire logic [7:0]  i_stream_byte,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_only_adaptation_headers,
    output logic             o_rec_valid,
    input  wire logic        i_rec_ready,
    output logic [1:0]       o_record_kind,
    output logic [12:0]      o_packet_id,
    output logic             o_transport_error,
    output logic             o_unit_start,
    output logic             o_priority_bit,
    output logic [1:0]       o_scrambling,
    output logic [1:0]       o_adaptation_control,
    output logic [3:0]       o_continuity,
    output logic [7:0]       o_adaptation_length,
    output logic [7:0]       o_adaptation_flags,
    output logic [7:0]       o_payload_length,
    output logic [7:0]       o_payload_data
);

    logic       r_only_adapt;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_free;
    logic       take;
    logic       dec_has;
    t_record    dec_rec;
    t_record    out_rec;

    assign o_cfg_ready = 1'b1;
    assign take        = in_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_only_adapt <= 1'b0;
        end else if (i_cfg_valid) begin
            r_only_adapt <= i_cfg_only_adaptation_headers;
        end
    end

    tsp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_stream_valid),
        .o_ready (o_stream_ready),
        .i_byte  (i_stream_byte),
        .i_take  (take),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    tsp_decoder #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_dec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (take),
        .i_byte       (in_byte),
        .i_only_adapt (r_only_adapt),
        .o_has        (dec_has),
        .o_rec        (dec_rec)
    );

    tsp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_has   (dec_has),
        .i_rec   (dec_rec),
        .o_free  (out_free),
        .o_valid (o_rec_valid),
        .i_ready (i_rec_ready),
        .o_rec   (out_rec)
    );

    assign o_record_kind        = out_rec.record_kind;
    assign o_packet_id          = out_rec.packet_id;
    assign o_transport_error    = out_rec.transport_error;
    assign o_unit_start         = out_rec.unit_start;
    assign o_priority_bit       = out_rec.priority_bit;
    assign o_scrambling         = out_rec.scrambling;
    assign o_adaptation_control = out_rec.adaptation_control;
    assign o_continuity         = out_rec.continuity;
    assign o_adaptation_length  = out_rec.adaptation_length;
    assign o_adaptation_flags   = out_rec.adaptation_flags;
    assign o_payload_length     = out_rec.payload_length;
    assign o_payload_data       = out_rec.payload_data;

endmodule

`default_nettype wire

FILE: test/ts_packet_header_parser_tb.sv
// Self-checking testbench for ts_packet_header_parser: directed packets, then random ones.
// Every accepted output record is compared against a built-in packet parser model.
// Depends on tsp_pkg and the ts_packet_header_parser RTL.
`timescale 1ns / 100ps

module ts_packet_header_parser_tb;
    import tsp_pkg::*;

    localparam int PACKET_BYTES = 188;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_PACKETS = 1;    // per random phase

    typedef struct {
        bit               cfg;
        logic [0:5][7:0]  head;     // bytes 0..5 of the packet, rest is random fill
        bit               typed;
        t_record          want;     // first record of the packet when typed is set
    } t_packet_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_stream_valid = 1'b0;
    logic [7:0]  i_stream_byte = 8'd0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_only_adaptation_headers = 1'b0;
    logic        i_rec_ready = 1'b0;
    logic        o_stream_ready;
    logic        o_cfg_ready;
    logic        o_rec_valid;
    logic [1:0]  o_record_kind;
    logic [12:0] o_packet_id;
    logic        o_transport_error;
    logic        o_unit_start;
    logic        o_priority_bit;
    logic [1:0]  o_scrambling;
    logic [1:0]  o_adaptation_control;
    logic [3:0]  o_continuity;
    logic [7:0]  o_adaptation_length;
    logic [7:0]  o_adaptation_flags;
    logic [7:0]  o_payload_length;
    logic [7:0]  o_payload_data;

    ts_packet_header_parser #(.PACKET_BYTES(PACKET_BYTES)) dut (
        .i_clk                         (i_clk),
        .i_rst_n                       (i_rst_n),
        .i_stream_valid                (i_stream_valid),
        .o_stream_ready                (o_stream_ready),
        .i_stream_byte                 (i_stream_byte),
        .i_cfg_valid                   (i_cfg_valid),
        .o_cfg_ready                   (o_cfg_ready),
        .i_cfg_only_adaptation_headers (i_cfg_only_adaptation_headers),
        .o_rec_valid                   (o_rec_valid),
        .i_rec_ready                   (i_rec_ready),
        .o_record_kind                 (o_record_kind),
        .o_packet_id                   (o_packet_id),
        .o_transport_error             (o_transport_error),
        .o_unit_start                  (o_unit_start),
        .o_priority_bit                (o_priority_bit),
        .o_scrambling                  (o_scrambling),
        .o_adaptation_control          (o_adaptation_control),
        .o_continuity                  (o_continuity),
        .o_adaptation_length           (o_adaptation_length),
        .o_adaptation_flags            (o_adaptation_flags),
        .o_payload_length              (o_payload_length),
        .o_payload_data                (o_payload_data)
    );

    always #5 i_clk = ~i_clk;

    // parser model state
    logic [7:0]  pkt_pos = 8'd0;
    logic        pkt_dropped = 1'b0;
    logic [23:0] hdr_bytes = 24'd0;
    logic [7:0]  af_len = 8'd0;
    logic [7:0]  payload_first = 8'd0;
    logic        only_af = 1'b0;

    t_record     pending_records[$];
    t_record     typed_want = '0;
    logic        typed_pending = 1'b0;
    t_record     model_rec;
    t_record     seen_rec;
    t_record     want_rec;

    int          send_idle = 0;
    int          rec_stall = 0;
    int          mismatches = 0;
    int          cycles = 0;
    t_packet_row directed_rows[$];

    function automatic bit header_record(input logic [7:0] alen, input logic [7:0] aflags,
                                         output t_record rec);
        int plen;
        rec = '0;
        if (only_af && !hdr_bytes[5])
            return 1'b0;
        plen = (hdr_bytes[4] && payload_first < PACKET_BYTES) ?
               PACKET_BYTES - payload_first : 0;
        rec.record_kind        = KIND_HEADER;
        rec.packet_id          = hdr_bytes[20:8];
        rec.transport_error    = hdr_bytes[23];
        rec.unit_start         = hdr_bytes[22];
        rec.priority_bit       = hdr_bytes[21];
        rec.scrambling         = hdr_bytes[7:6];
        rec.adaptation_control = hdr_bytes[5:4];
        rec.continuity         = hdr_bytes[3:0];
        rec.adaptation_length  = alen;
        rec.adaptation_flags   = aflags;
        rec.payload_length     = 8'(plen);
        return 1'b1;
    endfunction

    // Advances the model by one stream byte; returns 1 when a record comes out.
    function automatic bit parse_byte(input logic [7:0] b, output t_record rec);
        bit emitted;
        int start;
        emitted = 1'b0;
        rec = '0;
        if (pkt_pos == 8'd0) begin
            pkt_dropped = (b != SYNC_MARK);
            if (pkt_dropped) begin
                rec.record_kind = KIND_SYNC_ERR;
                emitted = 1'b1;
            end
        end else if (!pkt_dropped) begin
            if (pkt_pos <= 8'd3) begin
                hdr_bytes = {hdr_bytes[15:0], b};
                if (pkt_pos == 8'd3) begin
                    af_len = 8'd0;
                    if (hdr_bytes[5]) begin
                        payload_first = 8'(PACKET_BYTES);
                    end else begin
                        payload_first = 8'd4;
                        emitted = header_record(8'd0, 8'd0, rec);
                    end
                end
            end else if (hdr_bytes[5] && pkt_pos == 8'd4) begin
                // length byte counts toward the payload offset; overlong saturates
                start = 5 + int'(b);
                af_len = b;
                payload_first = 8'((start > PACKET_BYTES) ? PACKET_BYTES : start);
                if (b == 8'd0)
                    emitted = header_record(8'd0, 8'd0, rec);
            end else if (hdr_bytes[5] && pkt_pos == 8'd5 && af_len != 8'd0) begin
                emitted = header_record(af_len, b, rec);
            end else if (hdr_bytes[4] && pkt_pos >= payload_first) begin
                rec.record_kind  = KIND_PAYLOAD;
                rec.payload_data = b;
                emitted = 1'b1;
            end
        end
        pkt_pos = (int'(pkt_pos) + 1 >= PACKET_BYTES) ? 8'd0 : pkt_pos + 8'd1;
        return emitted;
    endfunction

    function automatic string rec_text(input t_record r);
        return $sformatf({"kind %0d pid %h tei %b pusi %b pri %b sc %0d afc %0d cc %0d ",
                          "alen %0d aflg %h plen %0d data %h"},
                         r.record_kind, r.packet_id, r.transport_error, r.unit_start,
                         r.priority_bit, r.scrambling, r.adaptation_control, r.continuity,
                         r.adaptation_length, r.adaptation_flags, r.payload_length,
                         r.payload_data);
    endfunction

    task automatic note_mismatch(input string what, input t_record want,
                                 input t_record seen);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s", $realtime, what);
            $display("    expected %s", rec_text(want));
            $display("    actual   %s", rec_text(seen));
        end
    endtask

    // model update on accepted words, check on delivered records
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pkt_pos       = 8'd0;
            pkt_dropped   = 1'b0;
            hdr_bytes     = 24'd0;
            af_len        = 8'd0;
            payload_first = 8'd0;
            only_af       = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                only_af = i_cfg_only_adaptation_headers;
            if (i_stream_valid && o_stream_ready) begin
                if (parse_byte(i_stream_byte, model_rec)) begin
                    if (typed_pending) begin
                        pending_records.push_back(typed_want);
                        typed_pending <= 1'b0;
                    end else begin
                        pending_records.push_back(model_rec);
                    end
                end
            end
            if (o_rec_valid && i_rec_ready) begin
                seen_rec = {t_kind'(o_record_kind), o_packet_id, o_transport_error,
                            o_unit_start, o_priority_bit, o_scrambling,
                            o_adaptation_control, o_continuity, o_adaptation_length,
                            o_adaptation_flags, o_payload_length, o_payload_data};
                if (pending_records.size() == 0) begin
                    note_mismatch("record with nothing expected", '0, seen_rec);
                end else begin
                    want_rec = pending_records.pop_front();
                    if (seen_rec !== want_rec)
                        note_mismatch("record mismatch", want_rec, seen_rec);
                end
            end
        end
    end

    always @(posedge i_clk)
        i_rec_ready <= ($urandom_range(99) >= rec_stall);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle) begin
            i_stream_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_stream_valid <= 1'b1;
        i_stream_byte  <= b;
        do @(posedge i_clk); while (!o_stream_ready);
    endtask

    task automatic send_packet(input logic [0:5][7:0] head, input bit typed,
                               input t_record want);
        if (typed) begin
            typed_pending <= 1'b1;
            typed_want    <= want;
        end
        for (int p = 0; p < PACKET_BYTES; p++)
            send_byte((p < 6) ? head[p] : 8'($urandom));
    endtask

    // Header bytes give no record, so wait out the pipeline after the last record.
    // The first edge lets the model log the word accepted at the current edge.
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending_records.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input bit v);
        i_stream_valid <= 1'b0;
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_only_adaptation_headers <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input bit cfg, input logic [0:5][7:0] head, input bit typed,
                           input t_record want);
        t_packet_row row;
        row.cfg   = cfg;
        row.head  = head;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    initial begin
        bit              cur_cfg;
        logic [0:5][7:0] head;

        // no adaptation field, max PID
        add_row(1'b0, {8'h47, 8'h1f, 8'hff, 8'h10, 8'h00, 8'h00}, 1'b1,
                {KIND_HEADER, 13'h1fff, 1'b0, 1'b0, 1'b0, 2'd0, 2'd1, 4'd0,
                 8'd0, 8'd0, 8'd184, 8'd0});
        // all header bits set, adaptation length zero
        add_row(1'b0, {8'h47, 8'hff, 8'hff, 8'hff, 8'h00, 8'h55}, 1'b1,
                {KIND_HEADER, 13'h1fff, 1'b1, 1'b1, 1'b1, 2'd3, 2'd3, 4'd15,
                 8'd0, 8'd0, 8'd183, 8'd0});
        // reserved adaptation control, all-zero header
        add_row(1'b0, {8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
                {KIND_HEADER, 13'h0000, 1'b0, 1'b0, 1'b0, 2'd0, 2'd0, 4'd0,
                 8'd0, 8'd0, 8'd0, 8'd0});
        // adaptation length far beyond the packet
        add_row(1'b0, {8'h47, 8'h40, 8'h00, 8'h3a, 8'hff, 8'h5a}, 1'b1,
                {KIND_HEADER, 13'h0000, 1'b0, 1'b1, 1'b0, 2'd0, 2'd3, 4'd10,
                 8'd255, 8'h5a, 8'd0, 8'd0});
        // one payload byte left
        add_row(1'b0, {8'h47, 8'ha0, 8'h01, 8'h3f, 8'd182, 8'hc3}, 1'b1,
                {KIND_HEADER, 13'h0001, 1'b1, 1'b0, 1'b1, 2'd0, 2'd3, 4'd15,
                 8'd182, 8'hc3, 8'd1, 8'd0});
        // payload offset lands exactly at the packet end
        add_row(1'b0, {8'h47, 8'h12, 8'h34, 8'hb7, 8'd183, 8'h01}, 1'b1,
                {KIND_HEADER, 13'h1234, 1'b0, 1'b0, 1'b0, 2'd2, 2'd3, 4'd7,
                 8'd183, 8'h01, 8'd0, 8'd0});
        // adaptation field only, no payload
        add_row(1'b0, {8'h47, 8'h01, 8'h00, 8'h20, 8'd7, 8'h80}, 1'b1,
                {KIND_HEADER, 13'h0100, 1'b0, 1'b0, 1'b0, 2'd0, 2'd2, 4'd0,
                 8'd7, 8'h80, 8'd0, 8'd0});
        // filtered: header suppressed, payload still passes
        add_row(1'b1, {8'h47, 8'h1f, 8'hff, 8'h10, 8'h00, 8'h00}, 1'b0, '0);
        add_row(1'b1, {8'h46, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00}, 1'b1,
                {KIND_SYNC_ERR, 56'd0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cur_cfg = 1'b0;
        write_cfg(cur_cfg);
        foreach (directed_rows[r]) begin
            if (directed_rows[r].cfg != cur_cfg) begin
                cur_cfg = directed_rows[r].cfg;
                write_cfg(cur_cfg);
            end
            send_packet(directed_rows[r].head, directed_rows[r].typed,
                        directed_rows[r].want);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  rec_stall = 0;  cur_cfg = 1'b1; end
                1: begin send_idle = 87; rec_stall = 0;  cur_cfg = 1'b0; end
                2: begin send_idle = 0;  rec_stall = 87; cur_cfg = 1'b1; end
                default: begin send_idle = 29; rec_stall = 29; cur_cfg = 1'b0; end
            endcase
            write_cfg(cur_cfg);
            for (int k = 0; k < RAND_PACKETS; k++) begin
                head[0] = ($urandom_range(99) < 90) ? SYNC_MARK : 8'($urandom);
                head[1] = 8'($urandom);
                head[2] = 8'($urandom);
                head[3] = 8'($urandom);
                case ($urandom_range(3))
                    0: head[4] = 8'd0;
                    1: head[4] = 8'($urandom_range(16, 1));
                    2: head[4] = 8'($urandom_range(255, 170));
                    default: head[4] = 8'($urandom);
                endcase
                head[5] = 8'($urandom);
                send_packet(head, 1'b0, '0);
            end
        end

        i_stream_valid <= 1'b0;
        wait_idle();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
